[design/gcf_pkg.sv]
`default_nettype none
// ============================================================================
// gcf_pkg
// Shared types and constants of the gradient contour filter: field widths,
// configuration register indexes and the work entry passed front to back.
// ============================================================================
package gcf_pkg;

    localparam int PIXEL_W    = 8;
    localparam int VALUE_W    = 9;
    localparam int POS_W      = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = t_cfg_idx'(1);

    // result slots of one entry, in delivery order
    localparam int RES_UP   = 0;
    localparam int RES_LEFT = 1;
    localparam int RES_SELF = 2;
    localparam int RES_N    = 3;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [RES_N-1:0]   mask;
        logic [VALUE_W-1:0] val_up;
        logic [VALUE_W-1:0] val_left;
        logic [VALUE_W-1:0] val_self;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
    } t_entry;

    typedef struct packed {
        logic   wr;
        t_entry entry;
    } t_q_req;

endpackage
`default_nettype wire

[design/gcf_front.sv]
`default_nettype none
// ============================================================================
// gcf_front
// Pixel intake: frame counters, size registers, line store with look-ahead
// read, difference computation and entry generation toward the queue.
// ============================================================================
module gcf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [gcf_pkg::PIXEL_W-1:0]  i_pixel,
    output logic                              o_full,
    input  wire logic                         i_cfg_valid,
    input  wire gcf_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [gcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         i_q_full,
    output gcf_pkg::t_q_req                   o_q_req
);
    import gcf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int PW  = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
    localparam int VW  = PW + 1;
    localparam int SWW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SWH = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
    localparam int RST_W = (1024 > MAX_WIDTH)  ? MAX_WIDTH  : 1024;
    localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    logic [PW-1:0] r_line [MAX_WIDTH];

    logic [CW-1:0] r_last_col, n_last_col;
    logic [RW-1:0] r_last_row, n_last_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] r_left;

    logic          r_s0_valid;
    logic [PW-1:0] r_s0_pix;
    logic [PW-1:0] r_s0_left;
    logic [CW-1:0] r_s0_col;
    logic [RW-1:0] r_s0_row;
    logic          r_s0_up;
    logic          r_s0_right;
    logic          r_s0_last_row;
    logic          r_s0_last_col;
    logic [PW-1:0] r_rd_data;
    logic [PW-1:0] r_above;

    logic          accept;
    logic          s0_adv;
    logic          cfg_wr;
    logic [PW-1:0] pix_in;
    logic [CW-1:0] rd_addr;
    logic          at_last_col;
    logic          at_last_row;
    logic [SWW-1:0] cfg_w;
    logic [SWH-1:0] cfg_h;
    logic [PW-1:0] ad_below;
    logic [PW-1:0] ad_right;
    logic [PW-1:0] ad_left;
    logic [VW-1:0] sum_up;
    logic [RES_N-1:0] mask;

    assign pix_in      = i_pixel[PW-1:0];
    assign o_full      = r_s0_valid && i_q_full;
    assign accept      = i_push && !o_full;
    assign s0_adv      = r_s0_valid && !i_q_full;
    assign cfg_wr      = i_cfg_valid &&
                         (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT);
    assign at_last_col = (r_col == r_last_col);
    assign at_last_row = (r_row == r_last_row);
    assign rd_addr     = at_last_col ? '0 : r_col + CW'(1);

    // clamp size writes into last-index form
    always_comb begin
        cfg_w      = SWW'(i_cfg_data);
        cfg_h      = SWH'(i_cfg_data);
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (i_cfg_valid && i_cfg_index == CFG_IMAGE_WIDTH) begin
            if (cfg_w == '0) begin
                n_last_col = '0;
            end else if (cfg_w > SWW'(MAX_WIDTH)) begin
                n_last_col = CW'(MAX_WIDTH - 1);
            end else begin
                n_last_col = CW'(cfg_w - SWW'(1));
            end
        end
        if (i_cfg_valid && i_cfg_index == CFG_IMAGE_HEIGHT) begin
            if (cfg_h == '0) begin
                n_last_row = '0;
            end else if (cfg_h > SWH'(MAX_HEIGHT)) begin
                n_last_row = RW'(MAX_HEIGHT - 1);
            end else begin
                n_last_row = RW'(cfg_h - SWH'(1));
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_W - 1);
            r_last_row <= RW'(RST_H - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
            if (cfg_wr) begin
                r_left <= '0;
            end else if (accept) begin
                r_left <= pix_in;
            end
            if (accept) begin
                r_s0_valid <= 1'b1;
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_pix      <= pix_in;
            r_s0_left     <= r_left;
            r_s0_col      <= r_col;
            r_s0_row      <= r_row;
            r_s0_up       <= (r_row != '0);
            r_s0_right    <= !at_last_col;
            r_s0_last_row <= at_last_row;
            r_s0_last_col <= at_last_col;
        end
        if (s0_adv) begin
            r_above <= r_rd_data;
        end
    end

    // line store: write this pixel, fetch the next column's upper sample
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line[r_col] <= pix_in;
            r_rd_data     <= (rd_addr == r_col) ? pix_in : r_line[rd_addr];
        end
    end

    always_comb begin
        ad_below = (r_s0_pix > r_above) ? r_s0_pix - r_above : r_above - r_s0_pix;
        ad_right = (r_rd_data > r_above) ? r_rd_data - r_above : r_above - r_rd_data;
        ad_left  = (r_s0_pix > r_s0_left) ? r_s0_pix - r_s0_left : r_s0_left - r_s0_pix;
        sum_up   = VW'(ad_below) + (r_s0_right ? VW'(ad_right) : VW'(0));
        mask[RES_UP]   = r_s0_up;
        mask[RES_LEFT] = r_s0_last_row && (r_s0_col != '0);
        mask[RES_SELF] = r_s0_last_row && r_s0_last_col;
    end

    always_comb begin
        o_q_req.wr             = s0_adv && (mask != '0);
        o_q_req.entry.mask     = mask;
        o_q_req.entry.val_up   = VALUE_W'(sum_up);
        o_q_req.entry.val_left = VALUE_W'(ad_left);
        o_q_req.entry.val_self = VALUE_W'(r_s0_pix);
        o_q_req.entry.row      = POS_W'(r_s0_row);
        o_q_req.entry.col      = POS_W'(r_s0_col);
    end

endmodule
`default_nettype wire

[design/gcf_queue.sv]
`default_nettype none
// ============================================================================
// gcf_queue
// Short entry queue decoupling the pixel front from the result back end.
// ============================================================================
module gcf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gcf_pkg::t_q_req i_req,
    output logic                 o_full,
    output logic                 o_empty,
    output gcf_pkg::t_entry      o_head,
    input  wire logic            i_pop
);
    import gcf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_req.wr && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_req.entry;
        end
    end

endmodule
`default_nettype wire

[design/gcf_back.sv]
`default_nettype none
// ============================================================================
// gcf_back
// Result sequencer: walks the results of the head entry in order and holds
// the current result in the output register until it is popped.
// ============================================================================
module gcf_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire gcf_pkg::t_entry               i_head,
    output logic                               o_q_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [gcf_pkg::VALUE_W-1:0]        o_contour_value,
    output logic [gcf_pkg::POS_W-1:0]          o_out_row,
    output logic [gcf_pkg::POS_W-1:0]          o_out_column,
    output logic                               o_last_of_run
);
    import gcf_pkg::*;

    logic               r_out_valid;
    logic [RES_N-1:0]   r_done, n_done;
    logic [RES_N-1:0]   avail;
    logic [RES_N-1:0]   pick;
    logic               pick_last;
    logic               load;
    logic [VALUE_W-1:0] n_value;
    logic [POS_W-1:0]   n_row;
    logic [POS_W-1:0]   n_col;

    assign avail     = i_head.mask & ~r_done;
    assign load      = !i_q_empty && (!r_out_valid || i_pop);
    assign pick_last = ((avail & ~pick) == '0);
    assign o_q_pop   = load && pick_last;
    assign o_empty   = !r_out_valid;

    always_comb begin
        pick = '0;
        if (avail[RES_UP]) begin
            pick[RES_UP] = 1'b1;
        end else if (avail[RES_LEFT]) begin
            pick[RES_LEFT] = 1'b1;
        end else begin
            pick[RES_SELF] = 1'b1;
        end
    end

    always_comb begin
        n_value = i_head.val_self;
        n_row   = i_head.row;
        n_col   = i_head.col;
        if (pick[RES_UP]) begin
            n_value = i_head.val_up;
            n_row   = i_head.row - POS_W'(1);
        end else if (pick[RES_LEFT]) begin
            n_value = i_head.val_left;
            n_col   = i_head.col - POS_W'(1);
        end
    end

    always_comb begin
        n_done = r_done;
        if (load) begin
            n_done = pick_last ? '0 : (r_done | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_contour_value <= n_value;
            o_out_row       <= n_row;
            o_out_column    <= n_col;
            o_last_of_run   <= pick_last;
        end
    end

endmodule
`default_nettype wire

[design/gradient_contour_filter_top.sv]
`default_nettype none
// ============================================================================
// gradient_contour_filter_top
// Forward-difference gradient contour filter over a raster pixel stream.
// ============================================================================
// Pixels are taken one per cycle in raster order while full is low; each result
// is tagged with the row and column of its pixel and the last result of each
// pixel that yields results is marked. The result port delivers one result per
// cycle while pop is held, so rows other than the last keep pace with the input,
// while last-row pixels (two results each, one in the first column) and the
// bottom-right pixel (three results) are slower. Between an accepted pixel and
// its result lie the stage-0 register with the line store read, the four-entry
// queue and the output register. Writing a size register restarts the frame;
// the line store needs no initialization.
module gradient_contour_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [gcf_pkg::PIXEL_W-1:0]    i_pixel,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [gcf_pkg::VALUE_W-1:0]         o_contour_value,
    output logic [gcf_pkg::POS_W-1:0]           o_out_row,
    output logic [gcf_pkg::POS_W-1:0]           o_out_column,
    output logic                                o_last_of_run,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire gcf_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [gcf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gcf_pkg::*;

    t_q_req q_req;
    t_entry q_head;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;

    gcf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_req     (q_req)
    );

    gcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    gcf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_head          (q_head),
        .o_q_pop         (q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_contour_value (o_contour_value),
        .o_out_row       (o_out_row),
        .o_out_column    (o_out_column),
        .o_last_of_run   (o_last_of_run)
    );

`ifndef ASSERT_OFF
    a_no_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_req.wr |-> !q_full)
        else $error("entry request while queue full");

    a_no_q_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_entry_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_empty |-> (q_head.mask != '0))
        else $error("queued entry carries no result");
`endif

endmodule
`default_nettype wire
